// ===== sv/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // Table geometry
   localparam int SLOTS       = 16;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int NREP_W      = $clog2(MAX_RESULTS + 1);

   // Field widths
   localparam int KIND_W   = 2;
   localparam int PERIOD_W = 16;
   localparam int SLOT_W   = 4;

   // Result status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_CREATE = 2'd1,
      KIND_KILL   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CREATE,
      ST_TICK,
      ST_TICK_END
   } state_type;

   // One slot of the task table
   typedef struct packed {
      logic                active;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] count;
      logic                once;
   } entry_type;

   // Table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } wr_type;

endpackage

// ===== sv/ptts_table.sv =====
// ----------------------------------------------------------------------------
// ptts_table
// Task slot table: one read port at the scan index, one full-entry write port.
// ----------------------------------------------------------------------------
module ptts_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [ptts_pkg::IDX_W-1:0] rd_idx,
   output ptts_pkg::entry_type       rd_entry,
   input  ptts_pkg::wr_type          wr
);
   import ptts_pkg::*;

   // Active bits are reset; payload is only read behind an active bit.
   logic [SLOTS-1:0]    active_ff;
   logic [PERIOD_W-1:0] period_ff [SLOTS];
   logic [PERIOD_W-1:0] count_ff  [SLOTS];
   logic                once_ff   [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (wr.en) begin
         active_ff[wr.idx] <= wr.data.active;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         period_ff[wr.idx] <= wr.data.period;
         count_ff[wr.idx]  <= wr.data.count;
         once_ff[wr.idx]   <= wr.data.once;
      end
   end

   always_comb begin
      rd_entry.active = active_ff[rd_idx];
      rd_entry.period = period_ff[rd_idx];
      rd_entry.count  = count_ff[rd_idx];
      rd_entry.once   = once_ff[rd_idx];
   end

endmodule

// ===== sv/ptts_slot_unit.sv =====
// ----------------------------------------------------------------------------
// ptts_slot_unit
// Shared compare/increment unit: decides whether the visited slot fires.
// ----------------------------------------------------------------------------
module ptts_slot_unit (
   input  logic [ptts_pkg::PERIOD_W-1:0] count,
   input  logic [ptts_pkg::PERIOD_W-1:0] period,
   output logic                          fire,
   output logic [ptts_pkg::PERIOD_W-1:0] count_next
);
   import ptts_pkg::*;

   assign fire       = (count >= period);
   assign count_next = fire ? '0 : count + PERIOD_W'(1);

endmodule

// ===== sv/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Task table with create, kill and tick transactions; slots visited serially.
// ----------------------------------------------------------------------------
// Kill, unused kind, zero-period create: busy stays low, result the cycle after start.
// Create: one slot visited per cycle until a free slot or the table end; result as busy falls.
// Tick: one slot per cycle through the shared unit, then a closing state
//   (ST_TICK_END); a fired result leaves when the next firing slot is visited,
//   the final one (last set) as busy falls.
// Reset clears every active bit at once; results show one cycle, no stall.
module periodic_task_tick_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ptts_pkg::KIND_W-1:0]   req_kind,
   input  logic [ptts_pkg::PERIOD_W-1:0] req_period,
   input  logic                          req_one_shot,
   input  logic [ptts_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_strobe,
   output logic                          rsp_status,
   output logic [ptts_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                          rsp_fired,
   output logic                          rsp_last
);
   import ptts_pkg::*;

   // Sequencer state
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;          // scan index
   logic [IDX_W-1:0]    pend_ff, pend_in;        // fired slot held back
   logic                pend_vld_ff, pend_vld_in;
   logic [NREP_W-1:0]   nrep_ff, nrep_in;        // fired slots reported so far
   logic [PERIOD_W-1:0] new_period_ff, new_period_in;
   logic                new_once_ff, new_once_in;

   // Result register
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_fired_ff, rsp_fired_in;
   logic                rsp_last_ff, rsp_last_in;

   // Table and shared unit
   entry_type           rd_entry;
   wr_type              wr;
   logic                fire;
   logic [PERIOD_W-1:0] count_next;
   logic                at_end;

   ptts_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   ptts_slot_unit u_unit (
      .count      (rd_entry.count),
      .period     (rd_entry.period),
      .fire       (fire),
      .count_next (count_next)
   );

   assign at_end = (idx_ff == IDX_W'(SLOTS - 1));
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         pend_vld_ff   <= 1'b0;
         nrep_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_vld_ff   <= pend_vld_in;
         nrep_ff       <= nrep_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      new_period_ff <= new_period_in;
      new_once_ff   <= new_once_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      nrep_in       = nrep_ff;
      new_period_in = new_period_ff;
      new_once_in   = new_once_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_last_in   = rsp_last_ff;

      wr.en   = 1'b0;
      wr.idx  = idx_ff;
      wr.data = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind_type'(req_kind))
                  KIND_TICK: begin
                     idx_in      = '0;
                     pend_vld_in = 1'b0;
                     nrep_in     = '0;
                     state_in    = ST_TICK;
                  end
                  KIND_CREATE: begin
                     if (req_period == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_REJECT;
                        rsp_slot_in   = '0;
                        rsp_fired_in  = 1'b0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        new_period_in = req_period;
                        new_once_in   = req_one_shot;
                        idx_in        = '0;
                        state_in      = ST_CREATE;
                     end
                  end
                  KIND_KILL: begin
                     // slots past the table are ignored but still answered
                     if (32'(req_slot) < SLOTS) begin
                        wr.en          = 1'b1;
                        wr.idx         = IDX_W'(req_slot);
                        wr.data.active = 1'b0;
                     end
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = req_slot;
                     rsp_fired_in  = 1'b0;
                     rsp_last_in   = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = '0;
                     rsp_fired_in  = 1'b0;
                     rsp_last_in   = 1'b1;
                  end
               endcase
            end
         end

         ST_CREATE: begin
            // lowest free slot wins
            if (!rd_entry.active) begin
               wr.en          = 1'b1;
               wr.data.active = 1'b1;
               wr.data.period = new_period_ff;
               wr.data.count  = '0;
               wr.data.once   = new_once_ff;
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = STATUS_OK;
               rsp_slot_in    = SLOT_W'(idx_ff);
               rsp_fired_in   = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end else if (at_end) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_REJECT;
               rsp_slot_in   = '0;
               rsp_fired_in  = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_TICK: begin
            if (rd_entry.active) begin
               wr.en          = 1'b1;
               wr.data.count  = count_next;
               wr.data.active = !(fire && rd_entry.once);
               // a firing is held back until the next one so the final one can carry last
               if (fire && (nrep_ff != NREP_W'(MAX_RESULTS))) begin
                  if (pend_vld_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = SLOT_W'(pend_ff);
                     rsp_fired_in  = 1'b1;
                     rsp_last_in   = 1'b0;
                  end
                  pend_in     = idx_ff;
                  pend_vld_in = 1'b1;
                  nrep_in     = nrep_ff + NREP_W'(1);
               end
            end
            if (at_end) begin
               state_in = ST_TICK_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_TICK_END: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = 1'b1;
            if (pend_vld_ff) begin
               rsp_slot_in  = SLOT_W'(pend_ff);
               rsp_fired_in = 1'b1;
            end else begin
               rsp_slot_in  = '0;
               rsp_fired_in = 1'b0;
            end
            pend_vld_in = 1'b0;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_fired      = rsp_fired_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== dv/periodic_task_tick_scheduler_chk.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_chk
// Watches the request and response channels of the task scheduler, keeps a
// shadow copy of the slot table, and checks every response against it.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [ptts_pkg::KIND_W-1:0]   req_kind,
   input  logic [ptts_pkg::PERIOD_W-1:0] req_period,
   input  logic                          req_one_shot,
   input  logic [ptts_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          rsp_strobe,
   input  logic                          rsp_status,
   input  logic [ptts_pkg::SLOT_W-1:0]   rsp_slot_index,
   input  logic                          rsp_fired,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import ptts_pkg::*;

   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot_index;
      logic              fired;
      logic              last;
   } sched_rsp_type;

   // shadow of the task table
   logic [PERIOD_W-1:0] tbl_period [SLOTS];
   logic [PERIOD_W-1:0] tbl_count  [SLOTS];
   logic                tbl_once   [SLOTS];

   sched_rsp_type due_rsps[$];
   int            bad = 0;

   assign fail_count = bad;

   task automatic flag(input string what, input int want_v, input int got_v);
      if (bad < PRINT_CAP)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      bad++;
   endtask

   task automatic clear_entry(input int i);
      tbl_period[i] = '0;
      tbl_count[i]  = '0;
      tbl_once[i]   = 1'b0;
   endtask

   // Apply one transaction to the shadow table; queue the responses it owes.
   task automatic table_step(input logic [KIND_W-1:0] kind, input logic [PERIOD_W-1:0] period,
                             input logic once, input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] hit[$];
      int                free_at;
      free_at = -1;
      case (kind)
         KIND_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_period[i] != '0) begin
                  if (tbl_count[i] >= tbl_period[i]) begin
                     tbl_count[i] = '0;
                     if (hit.size() < MAX_RESULTS)
                        hit.push_back(SLOT_W'(i));
                     if (tbl_once[i])
                        clear_entry(i);
                  end else begin
                     tbl_count[i] = tbl_count[i] + 1'b1;
                  end
               end
            end
            if (hit.size() == 0)
               due_rsps.push_back('{STATUS_OK, '0, 1'b0, 1'b1});
            for (int k = 0; k < hit.size(); k++)
               due_rsps.push_back('{STATUS_OK, hit[k], 1'b1, k == hit.size() - 1});
         end
         KIND_CREATE: begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (tbl_period[i] == '0)
                  free_at = i;
            if (period == '0 || free_at < 0) begin
               due_rsps.push_back('{STATUS_REJECT, '0, 1'b0, 1'b1});
            end else begin
               tbl_period[free_at] = period;
               tbl_count[free_at]  = '0;
               tbl_once[free_at]   = once;
               due_rsps.push_back('{STATUS_OK, SLOT_W'(free_at), 1'b0, 1'b1});
            end
         end
         KIND_KILL: begin
            if (int'(slot) < SLOTS)
               clear_entry(int'(slot));
            due_rsps.push_back('{STATUS_OK, slot, 1'b0, 1'b1});
         end
         default: begin
            due_rsps.push_back('{STATUS_OK, '0, 1'b0, 1'b1});
         end
      endcase
   endtask

   always @(posedge clock) begin
      sched_rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            clear_entry(i);
         due_rsps.delete();
      end else begin
         // responses first: nothing accepted at this edge can answer at it
         if (rsp_strobe) begin
            if (due_rsps.size() == 0) begin
               if (bad < PRINT_CAP)
                  $display({"%0t: unexpected response, expected none, ",
                            "actual status %0d slot %0d fired %0d last %0d"},
                           $time, rsp_status, rsp_slot_index, rsp_fired, rsp_last);
               bad++;
            end else begin
               want = due_rsps.pop_front();
               if (rsp_status !== want.status)
                  flag("status", want.status, rsp_status);
               if (rsp_slot_index !== want.slot_index)
                  flag("slot_index", want.slot_index, rsp_slot_index);
               if (rsp_fired !== want.fired)
                  flag("fired", want.fired, rsp_fired);
               if (rsp_last !== want.last)
                  flag("last", want.last, rsp_last);
            end
         end
         if (start && !busy)
            table_step(req_kind, req_period, req_one_shot, req_slot);
      end
      pending <= due_rsps.size();
   end

endmodule

// ===== dv/periodic_task_tick_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_tb
// Drives tick, create and kill transactions into the task scheduler with
// random gaps; a checker instance beside the block predicts and compares.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptts_pkg::*;

   // kind code the block must treat as a no-op
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 345;
   localparam int CALM_FIRST     = 120;   // no idling in [CALM_FIRST, CALM_LAST)
   localparam int CALM_LAST      = 200;
   localparam int DRAIN_AT       = 250;   // sender holds until all responses are in
   localparam int WATCHDOG_LIMIT = 1000;

   logic                clock;
   logic                reset        = 1'b1;
   logic                start        = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind     = '0;
   logic [PERIOD_W-1:0] req_period   = '0;
   logic                req_one_shot = 1'b0;
   logic [SLOT_W-1:0]   req_slot     = '0;
   logic                rsp_strobe;
   logic                rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic                rsp_fired;
   logic                rsp_last;

   int fail_count;
   int pending;
   int quiet_cycles = 0;

   periodic_task_tick_scheduler DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_period     (req_period),
      .req_one_shot   (req_one_shot),
      .req_slot       (req_slot),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_fired      (rsp_fired),
      .rsp_last       (rsp_last)
   );

   periodic_task_tick_scheduler_chk u_chk (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_period     (req_period),
      .req_one_shot   (req_one_shot),
      .req_slot       (req_slot),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_fired      (rsp_fired),
      .rsp_last       (rsp_last),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: any cycle without a request or response transaction counts.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Present one request and hold it until the block takes it. Called at a
   // rising edge; returns at the edge where the transaction was accepted, so
   // back-to-back calls keep start high without lowering it in between.
   task automatic issue(input logic [KIND_W-1:0] kind, input logic [PERIOD_W-1:0] period,
                        input logic once, input logic [SLOT_W-1:0] slot);
      req_kind     <= kind;
      req_period   <= period;
      req_one_shot <= once;
      req_slot     <= slot;
      start        <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Drop start for a random gap and put junk on the request fields; the
   // block must ignore them while start is low.
   task automatic sender_gap();
      start        <= 1'b0;
      req_kind     <= KIND_W'($urandom_range(3));
      req_period   <= PERIOD_W'($urandom);
      req_one_shot <= 1'($urandom_range(1));
      req_slot     <= SLOT_W'($urandom_range(15));
      repeat ($urandom_range(1, 4))
         @(posedge clock);
   endtask

   // Hold the request side until the checker has nothing outstanding.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // Mostly short periods so tasks actually fire; some zero (reject) and
   // some full-range values so every period bit toggles.
   function automatic logic [PERIOD_W-1:0] pick_period();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0:       return '0;
         1:       return PERIOD_W'($urandom);
         2:       return PERIOD_W'($urandom_range(6, 30));
         default: return PERIOD_W'($urandom_range(1, 4));
      endcase
   endfunction

   initial begin
      int                  roll;
      logic [KIND_W-1:0]   kind;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed -----------------------------------------------------
      issue(KIND_TICK, 16'd0, 1'b0, 4'd0);         // tick on empty table: no firing
      issue(KIND_KILL, 16'd0, 1'b0, 4'd15);        // kill of a free slot
      issue(KIND_UNUSED, 16'hFFFF, 1'b1, 4'd9);    // unused kind, ignored
      issue(KIND_CREATE, 16'd0, 1'b1, 4'd0);       // zero period: rejected
      // fill every slot, one-shot on odd slots
      for (int i = 0; i < SLOTS; i++)
         issue(KIND_CREATE, 16'd1, i[0], SLOT_W'(i));
      issue(KIND_CREATE, 16'hFFFF, 1'b0, 4'd0);    // table full: rejected
      issue(KIND_TICK, 16'd0, 1'b0, 4'd0);         // counts 0 -> 1, nothing fires
      issue(KIND_TICK, 16'hFFFF, 1'b1, 4'd15);     // all 16 fire, odd slots freed
      issue(KIND_CREATE, 16'hFFFF, 1'b1, 4'd0);    // max period into lowest free slot
      issue(KIND_KILL, 16'd0, 1'b0, 4'd0);         // kill an active slot
      drain();

      // ---- random -------------------------------------------------------
      // Ticks dominate so periods elapse; creates outnumber kills so the
      // table fills up now and then and full-table rejects show up.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == DRAIN_AT)
            drain();
         else if ((n < CALM_FIRST || n >= CALM_LAST) && $urandom_range(99) < 36)
            sender_gap();
         roll = $urandom_range(99);
         if (roll < 40)
            kind = KIND_TICK;
         else if (roll < 72)
            kind = KIND_CREATE;
         else if (roll < 95)
            kind = KIND_KILL;
         else
            kind = KIND_UNUSED;
         issue(kind, pick_period(), 1'($urandom_range(1)), SLOT_W'($urandom_range(15)));
      end

      // ---- wind down ----------------------------------------------------
      drain();
      repeat (SLOTS + 8) @(posedge clock);   // catch any stray late response
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ptts_pkg.sv
sv/ptts_table.sv
sv/ptts_slot_unit.sv
sv/periodic_task_tick_scheduler.sv
dv/periodic_task_tick_scheduler_chk.sv
dv/periodic_task_tick_scheduler_tb.sv
